[rtl/ids_pkg.sv]
// ids_pkg: shared constants, register codes and stage flag type for the
// isotropic diffusion sweep. No dependencies.
`timescale 1ns / 1ps

package ids_pkg;

  // defaults for the top level parameters
  localparam int MaxWidthDef  = 1024;
  localparam int PixelBitsDef = 16;

  // register and field widths
  localparam int KappaW     = 15;
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 13;
  localparam int RowW       = 12;
  localparam int ColOutW    = 10;
  localparam int PaddrW     = 4;
  localparam int DataW      = 32;
  localparam int FracBits   = 16;

  // register reset values and limits
  localparam int KappaReset  = 1638;
  localparam int WidthReset  = 1024;
  localparam int HeightReset = 1024;
  localparam int KappaMax    = 16384;
  localparam int MaxHeight   = 4096;
  localparam int MinDim      = 3;

  // result queue depth
  localparam int OutqDepth = 8;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    RegKappa  = 2'd0,
    RegWidth  = 2'd1,
    RegHeight = 2'd2
  } reg_idx_e;

  // per-pixel control that travels down the stencil pipeline
  typedef struct packed {
    logic valid;
    logic emit_up;   // pixel one row up is emitted
    logic copy;      // emitted pixel lies on the frame
    logic last_row;
    logic last_col;
  } flags_t;

endpackage

[rtl/ids_ram.sv]
// ids_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ids_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ids_stencil.sv]
// ids_stencil: line store read stage, five-point stencil multiply and
// rounding/saturation stage. Depends on ids_pkg.
`timescale 1ns / 1ps

module ids_stencil #(
  parameter int PIXEL_BITS = ids_pkg::PixelBitsDef,
  parameter int ADDR_W     = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ids_pkg::flags_t                        a_flags_i,
  input  logic [PIXEL_BITS-1:0]                  a_pix_i,
  input  logic [ids_pkg::RowW-1:0]               a_row_i,
  input  logic [ADDR_W-1:0]                      a_col_i,
  input  logic [ids_pkg::KappaW-1:0]             kappa_i,
  input  logic [PIXEL_BITS-1:0]                  one_rdata_i,
  input  logic [PIXEL_BITS-1:0]                  two_rdata_i,
  output logic                                   wr_en_o,
  output logic [ADDR_W-1:0]                      wr_addr_o,
  output logic [PIXEL_BITS-1:0]                  one_wdata_o,
  output logic [PIXEL_BITS-1:0]                  two_wdata_o,
  output logic [1:0]                             inflight_o,
  output logic                                   push0_o,
  output logic [PIXEL_BITS+ids_pkg::RowW+ids_pkg::ColOutW+1:0] data0_o,
  output logic                                   push1_o,
  output logic [PIXEL_BITS+ids_pkg::RowW+ids_pkg::ColOutW+1:0] data1_o
);

  localparam int SumW = PIXEL_BITS + 2;
  localparam int LapW = PIXEL_BITS + 3;
  localparam int PrdW = LapW + ids_pkg::KappaW + 1;
  localparam int TW   = PIXEL_BITS + ids_pkg::FracBits + 4;
  localparam logic [TW-1:0] Half = TW'(1) << (ids_pkg::FracBits - 1);

  // read stage registers
  ids_pkg::flags_t          b_flags_q;
  logic [PIXEL_BITS-1:0]    b_pix_q;
  logic [ids_pkg::RowW-1:0] b_row_q;
  logic [ADDR_W-1:0]        b_col_q;

  // sliding window: centre is the last right read, left the last centre
  logic [PIXEL_BITS-1:0]    centre_q;
  logic [PIXEL_BITS-1:0]    left_q;

  // write of the previous cycle, for same-entry forwarding
  logic                     wr_v_q;
  logic [ADDR_W-1:0]        wr_addr_q;
  logic [PIXEL_BITS-1:0]    wr_one_q;
  logic [PIXEL_BITS-1:0]    wr_two_q;

  // rounding stage registers
  ids_pkg::flags_t          c_flags_q;
  logic [PIXEL_BITS-1:0]    c_pix_q;
  logic [ids_pkg::RowW-1:0] c_row_q;
  logic [ADDR_W-1:0]        c_col_q;
  logic [PIXEL_BITS-1:0]    c_centre_q;
  logic signed [PrdW-1:0]   c_prod_q;

  logic [ADDR_W-1:0]        b_raddr;
  logic [PIXEL_BITS-1:0]    right;
  logic [PIXEL_BITS-1:0]    up;
  logic [SumW-1:0]          sum4;
  logic signed [LapW-1:0]   lap;
  logic signed [PrdW-1:0]   prod;
  logic [TW-1:0]            t_sum;
  logic [PIXEL_BITS-1:0]    smooth;
  logic [PIXEL_BITS-1:0]    res;
  logic [ids_pkg::ColOutW-1:0] c_col_out;

  // right neighbour address as issued at accept time
  assign b_raddr = b_flags_q.last_col ? '0 : b_col_q + ADDR_W'(1);

  // forward when the read hit the entry written at the same edge
  assign right = (wr_v_q && (wr_addr_q == b_raddr)) ? wr_one_q : one_rdata_i;
  assign up    = (wr_v_q && (wr_addr_q == b_col_q)) ? wr_two_q : two_rdata_i;

  // laplacian and weight
  assign sum4 = SumW'(up) + SumW'(b_pix_q) + SumW'(left_q) + SumW'(right);
  assign lap  = $signed({1'b0, sum4}) - $signed({1'b0, centre_q, 2'b00});
  assign prod = $signed({1'b0, kappa_i}) * lap;

  // line store write back
  assign wr_en_o     = b_flags_q.valid;
  assign wr_addr_o   = b_col_q;
  assign one_wdata_o = b_pix_q;
  assign two_wdata_o = centre_q;

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_flags_q <= '0;
      c_flags_q <= '0;
      wr_v_q    <= 1'b0;
    end else begin
      b_flags_q <= a_flags_i;
      c_flags_q <= b_flags_q;
      wr_v_q    <= b_flags_q.valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    b_pix_q    <= a_pix_i;
    b_row_q    <= a_row_i;
    b_col_q    <= a_col_i;
    wr_addr_q  <= b_col_q;
    wr_one_q   <= b_pix_q;
    wr_two_q   <= centre_q;
    c_pix_q    <= b_pix_q;
    c_row_q    <= b_row_q;
    c_col_q    <= b_col_q;
    c_centre_q <= centre_q;
    c_prod_q   <= prod;
    if (b_flags_q.valid) begin
      centre_q <= right;
      left_q   <= centre_q;
    end
  end

  // round half up and saturate
  always_comb begin
    t_sum = {4'b0000, c_centre_q, {ids_pkg::FracBits{1'b0}}}
          + {{(TW - PrdW){c_prod_q[PrdW-1]}}, c_prod_q} + Half;
    if (t_sum[TW-1]) begin
      smooth = '0;
    end else if (|t_sum[TW-2:PIXEL_BITS+ids_pkg::FracBits]) begin
      smooth = '1;
    end else begin
      smooth = t_sum[PIXEL_BITS+ids_pkg::FracBits-1:ids_pkg::FracBits];
    end
    res = c_flags_q.copy ? c_centre_q : smooth;
  end

  // result beats: pixel one row up, then the arriving pixel on the last row
  assign c_col_out = ids_pkg::ColOutW'(c_col_q);
  assign push0_o = c_flags_q.valid & c_flags_q.emit_up;
  assign data0_o = {res, ids_pkg::RowW'(c_row_q - ids_pkg::RowW'(1)), c_col_out,
                    ~c_flags_q.last_row, 1'b0};
  assign push1_o = c_flags_q.valid & c_flags_q.last_row;
  assign data1_o = {c_pix_q, c_row_q, c_col_out, 1'b1, c_flags_q.last_col};

  assign inflight_o = {1'b0, b_flags_q.valid} + {1'b0, c_flags_q.valid};

endmodule

[rtl/ids_outq.sv]
// ids_outq: result queue that takes up to two beats per cycle and hands out
// one. Depends on ids_pkg for its default depth.
`timescale 1ns / 1ps

module ids_outq #(
  parameter int WIDTH = 40,
  parameter int DEPTH = ids_pkg::OutqDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push0_i,
  input  logic [WIDTH-1:0]           data0_i,
  input  logic                       push1_i,
  input  logic [WIDTH-1:0]           data1_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [WIDTH-1:0]           data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             any_push;
  logic             both_push;
  logic [WIDTH-1:0] first_data;

  assign any_push   = push0_i | push1_i;
  assign both_push  = push0_i & push1_i;
  assign first_data = push0_i ? data0_i : data1_i;

  // pointer and fill count
  always_comb begin
    wp_d = wp_q;
    if (both_push) begin
      wp_d = ptr_inc(ptr_inc(wp_q));
    end else if (any_push) begin
      wp_d = ptr_inc(wp_q);
    end
    rp_d = pop_i ? ptr_inc(rp_q) : rp_q;
    count_d = count_q + CntW'(push0_i) + CntW'(push1_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (any_push) begin
      mem_q[wp_q] <= first_data;
    end
    if (both_push) begin
      mem_q[ptr_inc(wp_q)] <= data1_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rp_q];
  assign count_o = count_q;

endmodule

[rtl/isotropic_diffusion_sweep.sv]
// isotropic_diffusion_sweep: one five-point diffusion pass over a raster stream.
// Path: a result beat passes the read stage, the rounding stage and the result queue.
// Throughput: one input beat per cycle while in_stall_o is low; last-row beats yield
// two results, which the single output port hands out one at a time.
// Reset: asynchronous, clears position, pipeline, result queue and registers only.
// Depends on ids_pkg, ids_ram, ids_stencil, ids_outq.
`timescale 1ns / 1ps

module isotropic_diffusion_sweep #(
  parameter int MAX_WIDTH  = ids_pkg::MaxWidthDef,
  parameter int PIXEL_BITS = ids_pkg::PixelBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ids_pkg::PaddrW-1:0]   paddr,
  input  logic [ids_pkg::DataW-1:0]    pwdata,
  output logic [ids_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  // pixel input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [PIXEL_BITS-1:0]        pixel_in_i,
  input  logic                         first_pixel_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [PIXEL_BITS-1:0]        pixel_out_o,
  output logic [ids_pkg::RowW-1:0]     out_row_o,
  output logic [ids_pkg::ColOutW-1:0]  out_col_o,
  output logic                         last_of_run_o,
  output logic                         image_done_o
);

  localparam int AddrW = $clog2(MAX_WIDTH);
  localparam int WCntW = $clog2(MAX_WIDTH + 1);
  localparam int HCntW = ids_pkg::HeightRegW;
  localparam int ResW  = PIXEL_BITS + ids_pkg::RowW + ids_pkg::ColOutW + 2;
  localparam int CntW  = $clog2(ids_pkg::OutqDepth + 1);

  logic [ids_pkg::KappaW-1:0]     kappa_q;
  logic [ids_pkg::WidthRegW-1:0]  width_q;
  logic [ids_pkg::HeightRegW-1:0] height_q;
  logic                           cfg_wr;
  logic [1:0]                     reg_idx;

  logic [ids_pkg::KappaW-1:0]     kappa_eff;
  logic [WCntW-1:0]               w_eff;
  logic [HCntW-1:0]               h_eff;

  logic [ids_pkg::RowW-1:0]       row_q, row_d, cur_row;
  logic [AddrW-1:0]               col_q, col_d, cur_col;
  logic                           restart;
  logic                           last_row;
  logic                           last_col;
  logic                           in_accept;
  logic                           out_accept;
  ids_pkg::flags_t                a_flags;

  logic [AddrW-1:0]               one_raddr;
  logic [PIXEL_BITS-1:0]          one_rdata;
  logic [PIXEL_BITS-1:0]          two_rdata;
  logic                           wr_en;
  logic [AddrW-1:0]               wr_addr;
  logic [PIXEL_BITS-1:0]          one_wdata;
  logic [PIXEL_BITS-1:0]          two_wdata;
  logic [1:0]                     inflight;
  logic                           push0, push1;
  logic [ResW-1:0]                data0, data1, head;
  logic [CntW-1:0]                outq_count;

  // register writes and reads
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kappa_q  <= ids_pkg::KappaW'(ids_pkg::KappaReset);
      width_q  <= ids_pkg::WidthRegW'(ids_pkg::WidthReset);
      height_q <= ids_pkg::HeightRegW'(ids_pkg::HeightReset);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ids_pkg::RegKappa:  kappa_q  <= pwdata[ids_pkg::KappaW-1:0];
        ids_pkg::RegWidth:  width_q  <= pwdata[ids_pkg::WidthRegW-1:0];
        ids_pkg::RegHeight: height_q <= pwdata[ids_pkg::HeightRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ids_pkg::RegKappa:  prdata = ids_pkg::DataW'(kappa_q);
      ids_pkg::RegWidth:  prdata = ids_pkg::DataW'(width_q);
      ids_pkg::RegHeight: prdata = ids_pkg::DataW'(height_q);
      default:            prdata = '0;
    endcase
  end

  // clamp register values to their working ranges
  always_comb begin
    if (32'(kappa_q) > ids_pkg::KappaMax) begin
      kappa_eff = ids_pkg::KappaW'(ids_pkg::KappaMax);
    end else begin
      kappa_eff = kappa_q;
    end
    if (32'(width_q) < ids_pkg::MinDim) begin
      w_eff = WCntW'(ids_pkg::MinDim);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WCntW'(MAX_WIDTH);
    end else begin
      w_eff = WCntW'(width_q);
    end
    if (32'(height_q) < ids_pkg::MinDim) begin
      h_eff = HCntW'(ids_pkg::MinDim);
    end else if (32'(height_q) > ids_pkg::MaxHeight) begin
      h_eff = HCntW'(ids_pkg::MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  // handshakes: reserve room for two results per beat in flight
  assign in_stall_o = (32'(outq_count) + 2 * 32'(inflight) + 2) > ids_pkg::OutqDepth;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_accept = out_valid_o & ~out_stall_i;

  // position of the arriving pixel
  always_comb begin
    restart  = first_pixel_i | (HCntW'(row_q) >= h_eff) | (WCntW'(col_q) >= w_eff);
    cur_row  = restart ? '0 : row_q;
    cur_col  = restart ? '0 : col_q;
    last_row = (HCntW'(cur_row) == (h_eff - HCntW'(1)));
    last_col = (WCntW'(cur_col) == (w_eff - WCntW'(1)));
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : cur_row + ids_pkg::RowW'(1);
    end else begin
      col_d = cur_col + AddrW'(1);
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // stage flags of the arriving pixel
  always_comb begin
    a_flags.valid    = in_accept;
    a_flags.emit_up  = (cur_row != '0);
    a_flags.copy     = (cur_row == ids_pkg::RowW'(1)) | (cur_col == '0) | last_col;
    a_flags.last_row = last_row;
    a_flags.last_col = last_col;
  end

  // right neighbour one row up; at the last column this fetches the next centre
  assign one_raddr = last_col ? '0 : cur_col + AddrW'(1);

  ids_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_row_one_up (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (one_wdata),
    .re_i    (in_accept),
    .raddr_i (one_raddr),
    .rdata_o (one_rdata)
  );

  ids_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_row_two_up (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (two_wdata),
    .re_i    (in_accept),
    .raddr_i (cur_col),
    .rdata_o (two_rdata)
  );

  ids_stencil #(
    .PIXEL_BITS (PIXEL_BITS),
    .ADDR_W     (AddrW)
  ) u_stencil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .a_flags_i   (a_flags),
    .a_pix_i     (pixel_in_i),
    .a_row_i     (cur_row),
    .a_col_i     (cur_col),
    .kappa_i     (kappa_eff),
    .one_rdata_i (one_rdata),
    .two_rdata_i (two_rdata),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .one_wdata_o (one_wdata),
    .two_wdata_o (two_wdata),
    .inflight_o  (inflight),
    .push0_o     (push0),
    .data0_o     (data0),
    .push1_o     (push1),
    .data1_o     (data1)
  );

  ids_outq #(
    .WIDTH (ResW),
    .DEPTH (ids_pkg::OutqDepth)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .data0_i (data0),
    .push1_i (push1),
    .data1_i (data1),
    .pop_i   (out_accept),
    .valid_o (out_valid_o),
    .data_o  (head),
    .count_o (outq_count)
  );

  // result beat fields
  assign {pixel_out_o, out_row_o, out_col_o, last_of_run_o, image_done_o} = head;

endmodule

[rtl/ids_checker.sv]
// ids_checker: port-level assertions on the result channel of the sweep,
// bound to isotropic_diffusion_sweep. Depends on ids_pkg.
`timescale 1ns / 1ps

module ids_checker #(
  parameter int PIXEL_BITS = ids_pkg::PixelBitsDef
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [PIXEL_BITS-1:0]       pixel_out_o,
  input logic [ids_pkg::RowW-1:0]    out_row_o,
  input logic [ids_pkg::ColOutW-1:0] out_col_o,
  input logic                        last_of_run_o,
  input logic                        image_done_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_out_o)
      && $stable(out_row_o) && $stable(out_col_o) && $stable(last_of_run_o)
      && $stable(image_done_o))
    else $error("stalled result beat changed");

  // the final pixel of an image closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_done_o |-> last_of_run_o)
    else $error("image done without last of run");

  // a run of two: the last-row pixel follows at once, same column, next row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o
      && (out_col_o == $past(out_col_o))
      && (out_row_o == ($past(out_row_o) + ids_pkg::RowW'(1))))
    else $error("second beat of a run missing or misplaced");

endmodule

bind isotropic_diffusion_sweep ids_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_ids_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pixel_out_o   (pixel_out_o),
  .out_row_o     (out_row_o),
  .out_col_o     (out_col_o),
  .last_of_run_o (last_of_run_o),
  .image_done_o  (image_done_o)
);

[dv/testbench.sv]
// testbench: streams raster images and register writes into isotropic_diffusion_sweep
// and checks every result beat against an in-bench five-point diffusion predictor.
// Depends on ids_pkg and the isotropic_diffusion_sweep rtl.
`timescale 1ns / 1ps

module testbench;
  import ids_pkg::*;

  localparam int PixW        = PixelBitsDef;
  localparam int MaxW        = MaxWidthDef;
  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 8;
  localparam int PhaseItems  = 130;

  typedef struct packed {
    logic [PixW-1:0]    pixel;
    logic [RowW-1:0]    row;
    logic [ColOutW-1:0] col;
    logic               last_of_run;
    logic               image_done;
  } swept_pixel_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_in_i;
  logic                first_pixel_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PixW-1:0]     pixel_out_o;
  logic [RowW-1:0]     out_row_o;
  logic [ColOutW-1:0]  out_col_o;
  logic                last_of_run_o;
  logic                image_done_o;

  isotropic_diffusion_sweep dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .first_pixel_i(first_pixel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .last_of_run_o(last_of_run_o),
    .image_done_o (image_done_o)
  );

  // predictor copy of registers, line stores and raster position
  logic [KappaW-1:0]     kappa_reg;
  logic [WidthRegW-1:0]  width_reg;
  logic [HeightRegW-1:0] height_reg;
  logic [PixW-1:0]       line_two_up [MaxW];
  logic [PixW-1:0]       line_one_up [MaxW];
  int unsigned           cur_row;
  int unsigned           cur_col;

  swept_pixel_t swept_q[$];
  int           errors = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 10;
  int           recv_idle_pct = 69;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // five-point update, rounded half up and saturated
  function automatic logic [PixW-1:0] diffuse(input logic [PixW-1:0] centre,
                                              input logic [PixW-1:0] up,
                                              input logic [PixW-1:0] down,
                                              input logic [PixW-1:0] left,
                                              input logic [PixW-1:0] right,
                                              input int unsigned k);
    longint lap;
    longint acc;
    lap = longint'(up) + longint'(down) + longint'(left) + longint'(right)
          - 4 * longint'(centre);
    acc = (longint'(centre) << FracBits) + longint'(k) * lap + (longint'(1) << (FracBits - 1));
    if (acc < 0) return '0;
    acc = acc >>> FracBits;
    if (acc > ((longint'(1) << PixW) - 1)) return '1;
    return acc[PixW-1:0];
  endfunction

  // advance the predictor by one accepted pixel beat
  task automatic predict_sweep(input logic [PixW-1:0] pix, input logic first);
    int unsigned  k;
    int unsigned  w;
    int unsigned  h;
    int unsigned  r;
    int unsigned  c;
    logic         last_row;
    logic         last_col;
    logic [PixW-1:0] centre;
    swept_pixel_t beat;
    k = (kappa_reg > KappaMax) ? KappaMax : kappa_reg;
    w = width_reg;
    if (w < MinDim) w = MinDim;
    if (w > MaxW) w = MaxW;
    h = height_reg;
    if (h < MinDim) h = MinDim;
    if (h > MaxHeight) h = MaxHeight;
    if (first) begin
      cur_row = 0;
      cur_col = 0;
    end
    // position left outside a shrunken frame restarts the image
    if (cur_row >= h || cur_col >= w) begin
      cur_row = 0;
      cur_col = 0;
    end
    r = cur_row;
    c = cur_col;
    last_row = (r == h - 1);
    last_col = (c == w - 1);
    if (r >= 1) begin
      centre = line_one_up[c];
      if (r == 1 || c == 0 || last_col) begin
        beat.pixel = centre;
      end else begin
        beat.pixel = diffuse(centre, line_two_up[c], pix, line_two_up[c-1],
                             line_one_up[c+1], k);
      end
      beat.row         = RowW'(r - 1);
      beat.col         = ColOutW'(c);
      beat.last_of_run = !last_row;
      beat.image_done  = 1'b0;
      swept_q.push_back(beat);
    end
    if (last_row) begin
      beat.pixel       = pix;
      beat.row         = RowW'(r);
      beat.col         = ColOutW'(c);
      beat.last_of_run = 1'b1;
      beat.image_done  = last_col;
      swept_q.push_back(beat);
    end
    line_two_up[c] = line_one_up[c];
    line_one_up[c] = pix;
    if (last_col) begin
      cur_col = 0;
      cur_row = last_row ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
    end
  endtask

  // send one pixel beat, called and returning at a falling edge
  task automatic send_pixel(input logic [PixW-1:0] pix, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_in_i    <= pix;
    first_pixel_i <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_sweep(pix, first);
    @(negedge clk_i);
  endtask

  // let every expected beat arrive and the pipeline empty
  task automatic drain_sweep();
    in_valid_i <= 1'b0;
    while (swept_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // apb write: setup then access cycle, then back to idle
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegKappa:  kappa_reg = value[KappaW-1:0];
      RegWidth:  width_reg = value[WidthRegW-1:0];
      RegHeight: height_reg = value[HeightRegW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [DataW-1:0] kappa, input logic [DataW-1:0] width,
                              input logic [DataW-1:0] height);
    drain_sweep();
    write_reg(RegKappa, kappa);
    write_reg(RegWidth, width);
    write_reg(RegHeight, height);
  endtask

  // random pixel with the range ends weighted up
  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PixW'($urandom());
    endcase
  endfunction

  // one image start of count pixels, restart on the first and at random on others
  task automatic send_frame(input int unsigned count, input int noise_pct);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(pick_pixel(), (i == 0) || ($urandom_range(99) < noise_pct));
    end
  endtask

  // smallest frame, strongest kappa, range ends around the centre, then wrap
  task automatic test_frame_edges();
    logic [PixW-1:0] hi;
    hi = '1;
    set_geometry(KappaMax, MinDim, MinDim);
    send_pixel(hi, 1'b1);
    send_pixel('0, 1'b0);
    send_pixel(hi, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(hi, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(hi, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(hi, 1'b0);
    // position has wrapped, this one lands in row 0
    send_pixel(hi, 1'b0);
  endtask

  // kappa above a quarter and dimensions below three are clamped
  task automatic test_register_clamps();
    logic [PixW-1:0] hi;
    hi = '1;
    set_geometry((1 << KappaW) - 1, 1, 0);
    send_pixel('0, 1'b1);
    send_pixel(hi, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(hi, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(hi, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(hi, 1'b0);
    send_pixel('0, 1'b0);
  endtask

  // narrowing the frame under the current column restarts the image
  task automatic test_position_restart();
    set_geometry(0, 4, 4);
    send_frame(7, 0);
    drain_sweep();
    write_reg(RegWidth, MinDim);
    for (int i = 0; i < 4; i++) send_pixel(pick_pixel(), 1'b0);
  endtask

  // width register beyond the store size, opening pixels of the frame
  task automatic test_widest_frame();
    set_geometry($urandom_range(KappaMax), (1 << WidthRegW) - 1, MinDim);
    send_frame(MinDim * MinDim, 0);
  endtask

  // height register beyond the row limit, opening rows of the frame
  task automatic test_tallest_frame();
    set_geometry($urandom_range(KappaMax), MinDim, (1 << HeightRegW) - 1);
    send_frame(MinDim * MinDim, 0);
  endtask

  // small random frames, some cut short, a few stray restarts
  task automatic test_random_sweeps();
    int unsigned sent;
    int unsigned kappa;
    int unsigned width;
    int unsigned height;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned count;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        if (sent == 0 || $urandom_range(2) == 0) begin
          case ($urandom_range(5))
            0: kappa = 0;
            1: kappa = KappaMax;
            2: kappa = $urandom_range((1 << KappaW) - 1, KappaMax + 1);
            default: kappa = $urandom_range(KappaMax);
          endcase
          width  = ($urandom_range(9) == 0) ? $urandom_range(MinDim - 1) : $urandom_range(12, MinDim);
          height = ($urandom_range(9) == 0) ? $urandom_range(MinDim - 1) : $urandom_range(6, MinDim);
          set_geometry(kappa, width, height);
        end
        w_eff = (width_reg < MinDim) ? MinDim : width_reg;
        h_eff = (height_reg < MinDim) ? MinDim : height_reg;
        count = w_eff * h_eff;
        if ($urandom_range(4) == 0) count = $urandom_range(count - 1, 1);
        send_frame(count, 2);
        sent += count;
      end
    end
  endtask

  // receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    swept_pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (swept_q.size() == 0) begin
        $error("result beat with none expected: row %0d col %0d", out_row_o, out_col_o);
        errors++;
      end else begin
        want = swept_q.pop_front();
        check_field("pixel_out", 32'(want.pixel), 32'(pixel_out_o));
        check_field("out_row", 32'(want.row), 32'(out_row_o));
        check_field("out_col", 32'(want.col), 32'(out_col_o));
        check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run_o));
        check_field("image_done", 32'(want.image_done), 32'(image_done_o));
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, then the tests in turn
  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    pixel_in_i    = '0;
    first_pixel_i = 1'b0;
    kappa_reg     = KappaW'(KappaReset);
    width_reg     = WidthRegW'(WidthReset);
    height_reg    = HeightRegW'(HeightReset);
    cur_row       = 0;
    cur_col       = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_frame_edges();
    test_register_clamps();
    test_position_restart();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_widest_frame();
    test_tallest_frame();

    test_random_sweeps();

    drain_sweep();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ids_pkg.sv
rtl/ids_ram.sv
rtl/ids_stencil.sv
rtl/ids_outq.sv
rtl/isotropic_diffusion_sweep.sv
rtl/ids_checker.sv
dv/testbench.sv
